>>> hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int FUNC_W      = 2;
    localparam int ADDR7_W     = 7;
    localparam int LEN_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int TICKS_W     = 16;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index of unit_ticks (byte address 4*index)
    localparam logic [APB_ADDR_W-3:0] REG_UNIT_TICKS = 1'd0;
    localparam logic [TICKS_W-1:0]    UNIT_TICKS_RST = 16'd1;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               sda_in;
        logic [ADDR7_W-1:0] slave_address;
        logic               read_not_write;
        logic [LEN_W-1:0]   transfer_length;
        logic [BYTE_W-1:0]  write_byte;
    } item_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              want_byte;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              nack_seen;
        logic              busy_res;
        logic              done_res;
    } res_t;

endpackage

>>> hdl/i2cms_apb_regs.sv
// ----------------------------------------------------------------------------
// i2cms_apb_regs
// APB register file: holds unit_ticks (ticks per timing unit).
// ----------------------------------------------------------------------------
module i2cms_apb_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [i2cms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [i2cms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic [i2cms_pkg::TICKS_W-1:0]     unit_ticks
);
    import i2cms_pkg::*;

    logic [TICKS_W-1:0] unit_ticks_reg;
    logic               sel_unit_ticks;
    logic               wr_en;

    assign sel_unit_ticks = (paddr[APB_ADDR_W-1:2] == REG_UNIT_TICKS);
    assign wr_en          = psel && penable && pwrite;
    assign pready         = 1'b1;
    assign unit_ticks     = unit_ticks_reg;

    always_comb
    begin
        prdata = '0;
        if (sel_unit_ticks)
        begin
            prdata = {{(APB_DATA_W-TICKS_W){1'b0}}, unit_ticks_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RST;
        end
        else if (wr_en && sel_unit_ticks)
        begin
            unit_ticks_reg <= pwdata[TICKS_W-1:0];
        end
    end

endmodule

>>> hdl/i2cms_core.sv
// ----------------------------------------------------------------------------
// i2cms_core
// Bus sequencer state and one-step update; result register on the output.
// ----------------------------------------------------------------------------
module i2cms_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  i2cms_pkg::item_t              item,
    input  logic [i2cms_pkg::TICKS_W-1:0] unit_ticks,
    output logic                          res_valid,
    input  logic                          res_ready,
    output i2cms_pkg::res_t               res
);
    import i2cms_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_START = 4'd1;
    localparam logic [3:0] PH_ABIT  = 4'd2;
    localparam logic [3:0] PH_AACK  = 4'd3;
    localparam logic [3:0] PH_DBIT  = 4'd4;
    localparam logic [3:0] PH_DACK  = 4'd5;
    localparam logic [3:0] PH_WAIT  = 4'd6;
    localparam logic [3:0] PH_RPRE  = 4'd7;
    localparam logic [3:0] PH_RBIT  = 4'd8;
    localparam logic [3:0] PH_RACK  = 4'd9;
    localparam logic [3:0] PH_STOP  = 4'd10;

    logic [3:0]         phase_reg,      phase_next;
    logic [3:0]         bit_index_reg,  bit_index_next;
    logic [2:0]         unit_step_reg,  unit_step_next;
    logic [BYTE_W-1:0]  shift_byte_reg, shift_byte_next;
    logic [BYTE_W-1:0]  addr_byte_reg,  addr_byte_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [TICKS_W-1:0] tick_count_reg, tick_count_next;
    logic               is_read_reg,    is_read_next;
    logic               res_valid_reg;
    res_t               res_reg,        res_next;

    logic               fire;
    logic [TICKS_W-1:0] eff_ticks;
    logic               wbit;
    logic [2:0]         u;

    // phase after a byte and its acknowledge completed
    function automatic logic [3:0] after_byte(input logic [LEN_W-1:0] left,
                                              input logic rd);
        logic [3:0] p;
        begin
            if (left == '0)
                p = PH_STOP;
            else if (rd)
                p = PH_RPRE;
            else
                p = PH_WAIT;
            return p;
        end
    endfunction

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign eff_ticks  = (unit_ticks == '0) ? {{(TICKS_W-1){1'b0}}, 1'b1} : unit_ticks;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        unit_step_next  = unit_step_reg;
        shift_byte_next = shift_byte_reg;
        addr_byte_next  = addr_byte_reg;
        bytes_left_next = bytes_left_reg;
        tick_count_next = tick_count_reg;
        is_read_next    = is_read_reg;
        res_next        = '0;
        res_next.scl_level = 1'b1;
        res_next.sda_level = 1'b1;
        u               = unit_step_reg;

        // commands take effect before the lines are shown
        if (item.func == FUNC_BEGIN && phase_reg == PH_IDLE)
        begin
            addr_byte_next  = {item.slave_address, item.read_not_write};
            is_read_next    = item.read_not_write;
            bytes_left_next = item.transfer_length;
            phase_next      = PH_START;
            unit_step_next  = '0;
            bit_index_next  = '0;
            tick_count_next = '0;
        end
        else if (item.func == FUNC_BYTE && phase_reg == PH_WAIT)
        begin
            shift_byte_next = item.write_byte;
            phase_next      = PH_DBIT;
            unit_step_next  = '0;
            bit_index_next  = '0;
            tick_count_next = '0;
        end

        wbit = shift_byte_next[3'd7 - bit_index_next[2:0]];

        unique case (phase_next)
            PH_START:
            begin
                res_next.scl_level = (unit_step_next < 3'd2);
                res_next.sda_level = (unit_step_next == 3'd0);
            end
            PH_ABIT, PH_DBIT:
            begin
                res_next.scl_level = (unit_step_next < 3'd2);
                res_next.sda_level = wbit;
            end
            PH_AACK, PH_DACK:
            begin
                res_next.scl_level = (unit_step_next == 3'd1) || (unit_step_next == 3'd2);
            end
            PH_WAIT, PH_RPRE:
            begin
                res_next.scl_level = 1'b0;
            end
            PH_RBIT:
            begin
                res_next.scl_level = (unit_step_next < 3'd2);
            end
            PH_RACK:
            begin
                res_next.scl_level = (unit_step_next < 3'd2);
                res_next.sda_level = (bytes_left_next == {{(LEN_W-1){1'b0}}, 1'b1});
            end
            PH_STOP:
            begin
                res_next.scl_level = (unit_step_next >= 3'd1);
                res_next.sda_level = (unit_step_next == 3'd2);
            end
            default:
            begin
                res_next.scl_level = 1'b1;
            end
        endcase
        res_next.busy_res = (phase_next != PH_IDLE);

        if (item.func == FUNC_TICK && phase_next != PH_IDLE && phase_next != PH_WAIT)
        begin
            if ({1'b0, tick_count_next} + 17'd1 < {1'b0, eff_ticks})
            begin
                tick_count_next = tick_count_next + 1'b1;
            end
            else
            begin
                u               = unit_step_next;
                tick_count_next = '0;
                unit_step_next  = unit_step_next + 3'd1;
                unique case (phase_next)
                    PH_START:
                    begin
                        if (u == 3'd2)
                        begin
                            shift_byte_next = addr_byte_next;
                            phase_next      = PH_ABIT;
                            unit_step_next  = '0;
                            bit_index_next  = '0;
                        end
                    end
                    PH_ABIT, PH_DBIT:
                    begin
                        if (u == 3'd3)
                        begin
                            unit_step_next = '0;
                            bit_index_next = bit_index_next + 4'd1;
                            if (bit_index_next[3])
                            begin
                                phase_next     = phase_next + 4'd1;
                                bit_index_next = '0;
                            end
                        end
                    end
                    PH_AACK, PH_DACK:
                    begin
                        if (u == 3'd1)
                        begin
                            // ack slot: bit_index holds the sampled NACK flag
                            bit_index_next     = {3'd0, item.sda_in};
                            res_next.nack_seen = item.sda_in;
                        end
                        else if (u == 3'd4)
                        begin
                            if (bit_index_next != '0)
                            begin
                                phase_next = phase_next - 4'd1;
                            end
                            else if (phase_next == PH_AACK)
                            begin
                                phase_next = after_byte(bytes_left_next, is_read_next);
                            end
                            else
                            begin
                                bytes_left_next = bytes_left_next - 1'b1;
                                phase_next = after_byte(bytes_left_next, is_read_next);
                            end
                            unit_step_next = '0;
                            bit_index_next = '0;
                        end
                    end
                    PH_RPRE:
                    begin
                        if (u == 3'd1)
                        begin
                            shift_byte_next = '0;
                            phase_next      = PH_RBIT;
                            unit_step_next  = '0;
                            bit_index_next  = '0;
                        end
                    end
                    PH_RBIT:
                    begin
                        if (u == 3'd0)
                        begin
                            shift_byte_next = {shift_byte_next[BYTE_W-2:0], item.sda_in};
                        end
                        else if (u == 3'd3)
                        begin
                            unit_step_next = '0;
                            bit_index_next = bit_index_next + 4'd1;
                            if (bit_index_next[3])
                            begin
                                phase_next     = PH_RACK;
                                bit_index_next = '0;
                            end
                        end
                    end
                    PH_RACK:
                    begin
                        if (u == 3'd3)
                        begin
                            res_next.rx_valid = 1'b1;
                            res_next.rx_byte  = shift_byte_next;
                            bytes_left_next   = bytes_left_next - 1'b1;
                            phase_next     = after_byte(bytes_left_next, is_read_next);
                            unit_step_next = '0;
                            bit_index_next = '0;
                        end
                    end
                    PH_STOP:
                    begin
                        if (u == 3'd2)
                        begin
                            res_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                            unit_step_next    = '0;
                            bit_index_next    = '0;
                        end
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        unit_step_next = '0;
                        bit_index_next = '0;
                    end
                endcase
            end
        end

        res_next.want_byte = (phase_next == PH_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            unit_step_reg  <= '0;
            shift_byte_reg <= '0;
            addr_byte_reg  <= '0;
            bytes_left_reg <= '0;
            tick_count_reg <= '0;
            is_read_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg      <= phase_next;
                bit_index_reg  <= bit_index_next;
                unit_step_reg  <= unit_step_next;
                shift_byte_reg <= shift_byte_next;
                addr_byte_reg  <= addr_byte_next;
                bytes_left_reg <= bytes_left_next;
                tick_count_reg <= tick_count_next;
                is_read_reg    <= is_read_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> hdl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Bit-level I2C master: start, address, data bytes with acknowledge, stop.
// ----------------------------------------------------------------------------
// Each item on the request channel (a time tick, a begin command or a write
// byte) is taken into an input register and then processed by a single state
// update that loads the result register, so one item is accepted per clock
// while res_ready keeps the result side moving; its result is offered from there.
// Throughput is limited only by the result side: while res_valid is held by a
// low res_ready, the input register absorbs one more item and then stalls.
// unit_ticks (APB address 0, reset 1, zero acts as 1) sets how many tick
// items make one bus timing unit; write it only while no transfer is running.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [i2cms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [i2cms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,

    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [i2cms_pkg::FUNC_W-1:0]      func,
    input  logic                              sda_in,
    input  logic [i2cms_pkg::ADDR7_W-1:0]     slave_address,
    input  logic                              read_not_write,
    input  logic [i2cms_pkg::LEN_W-1:0]       transfer_length,
    input  logic [i2cms_pkg::BYTE_W-1:0]      write_byte,

    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              scl_level,
    output logic                              sda_level,
    output logic                              want_byte,
    output logic                              rx_valid,
    output logic [i2cms_pkg::BYTE_W-1:0]      rx_byte,
    output logic                              nack_seen,
    output logic                              busy_res,
    output logic                              done_res
);
    import i2cms_pkg::*;

    logic               in_valid_reg;
    item_t              item_reg;
    logic               core_ready;
    logic               req_fire;
    logic [TICKS_W-1:0] unit_ticks;
    res_t               res;

    assign req_ready = !in_valid_reg || core_ready;
    assign req_fire  = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (core_ready)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.func            <= func;
            item_reg.sda_in          <= sda_in;
            item_reg.slave_address   <= slave_address;
            item_reg.read_not_write  <= read_not_write;
            item_reg.transfer_length <= transfer_length;
            item_reg.write_byte      <= write_byte;
        end
    end

    i2cms_apb_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .unit_ticks (unit_ticks)
    );

    i2cms_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_ready (core_ready),
        .item       (item_reg),
        .unit_ticks (unit_ticks),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign scl_level = res.scl_level;
    assign sda_level = res.sda_level;
    assign want_byte = res.want_byte;
    assign rx_valid  = res.rx_valid;
    assign rx_byte   = res.rx_byte;
    assign nack_seen = res.nack_seen;
    assign busy_res  = res.busy_res;
    assign done_res  = res.done_res;

endmodule
